// File: rtl/core/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, quiet while reset is asserted.
`define DMD_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define DMD_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/dmd_pkg.sv
`default_nettype none

package dmd_pkg;

    localparam int DMD_ROW_BITS = 1024;

    localparam logic KIND_BIT    = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    typedef enum logic [1:0] {
        PH_SYNC,
        PH_DECODE,
        PH_DONE
    } dmd_phase_t;

    // Decoder state that one pass of the decode step works on.
    typedef struct packed {
        dmd_phase_t phase;
        logic [2:0] held_bits;
        logic [1:0] held_count;
        logic       clk_ref;
    } dmd_core_t;

    typedef struct packed {
        dmd_core_t  core;
        logic [1:0] adv;
        logic       emit_bit;
        logic       bit_value;
        logic       report;
        logic       halt;
    } dmd_iter_t;

    typedef struct packed {
        logic        kind;
        logic        value;
        logic [10:0] end_position;
        logic        final_res;
    } dmd_word_t;

    typedef struct packed {
        logic [1:0]          cnt;
        dmd_word_t [2:0]     word;
    } dmd_batch_t;

    // One decode step on the held half-bits. Bits above held_count are zero.
    function automatic dmd_iter_t dmd_iter(input dmd_core_t cur, input logic ended,
                                           input logic at_limit);
        dmd_iter_t  r;
        logic       stop;
        logic       take;
        logic [1:0] k;
        logic       b1;
        logic       b2;
        logic       b3;
        r.core      = cur;
        r.adv       = 2'd0;
        r.emit_bit  = 1'b0;
        r.bit_value = 1'b0;
        r.report    = 1'b0;
        r.halt      = 1'b0;
        stop = 1'b0;
        take = 1'b0;
        k    = 2'd0;
        b1   = cur.held_bits[0];
        b2   = cur.held_bits[1];
        b3   = cur.held_bits[2];

        if (at_limit) begin
            stop = 1'b1;
        end else if (cur.held_count == 2'd0) begin
            if (ended) begin
                stop = 1'b1;
            end else begin
                r.halt = 1'b1;
            end
        end

        if (!stop && !r.halt) begin
            if (cur.phase == PH_SYNC) begin
                if (cur.held_count < 2'd3 && !ended) begin
                    r.halt = 1'b1;
                end else if (b1 != b2) begin
                    if (b2 != b3) begin
                        r.emit_bit = 1'b1;
                        take       = 1'b1;
                        k          = 2'd2;
                    end else begin
                        r.core.clk_ref = b1;
                        r.core.phase   = PH_DECODE;
                        take           = 1'b1;
                        k              = 2'd1;
                    end
                end else begin
                    r.core.clk_ref = ~b1;
                    r.core.phase   = PH_DECODE;
                end
            end else begin
                if (b1 == cur.clk_ref) begin
                    take = 1'b1;
                    k    = 2'd1;
                    stop = 1'b1;
                end else if (cur.held_count < 2'd2 && !ended) begin
                    r.halt = 1'b1;
                end else begin
                    r.emit_bit     = 1'b1;
                    r.bit_value    = (b1 == b2);
                    r.core.clk_ref = b2;
                    take           = 1'b1;
                    k              = 2'd2;
                end
            end
        end

        if (take) begin
            r.adv = k;
            if (k >= cur.held_count) begin
                r.core.held_bits  = 3'd0;
                r.core.held_count = 2'd0;
            end else begin
                r.core.held_bits  = cur.held_bits >> k;
                r.core.held_count = cur.held_count - k;
            end
        end

        if (stop) begin
            r.report          = 1'b1;
            r.halt            = 1'b1;
            r.core.phase      = PH_DONE;
            r.core.held_bits  = 3'd0;
            r.core.held_count = 2'd0;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/dmd_result_buf.sv
`default_nettype none

// Three-slot result buffer: loads a whole batch, drains one word per cycle while out_ready is high.
module dmd_result_buf (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               load,
    input  wire dmd_pkg::dmd_batch_t batch,
    input  wire logic               out_ready,
    output logic                    out_valid,
    output dmd_pkg::dmd_word_t      out_word,
    output logic                    can_load
);
    import dmd_pkg::*;

    logic [1:0]      cnt_reg;
    logic [1:0]      cnt_next;
    dmd_word_t [2:0] slot_reg;
    logic            pop;

    assign out_valid = (cnt_reg != 2'd0);
    assign out_word  = slot_reg[0];
    assign pop       = out_valid && out_ready;
    // Empty once this cycle's pop is done.
    assign can_load  = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && out_ready);

    always_comb begin
        cnt_next = cnt_reg;
        if (load) begin
            cnt_next = batch.cnt;
        end else if (pop) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            slot_reg <= batch.word;
        end else if (pop) begin
            slot_reg[0] <= slot_reg[1];
            slot_reg[1] <= slot_reg[2];
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/differential_manchester_decoder.sv
`default_nettype none

// Channel   | Dir | Word                                  | Side info
// ----------+-----+---------------------------------------+-----------------------
// s_ stream | in  | tdata[0] half_bit                     | tlast row_end
// m_ stream | out | tdata[0] value, [11:1] end_position   | tuser kind, tlast final_res
// APB cfg   | in  | 0x0 start_offset, 0x4 max_pairs       | 10-bit registers
//
// An input word is registered, decoded combinationally and its result words (0 to 3)
// are loaded into a three-slot output buffer. A word making at most one result
// runs at one word per cycle while m_tready is high; one making two or three
// results holds the input until the buffer, draining one word per cycle while
// m_tready is high, is handing out its last word. The first result passes the
// input register, then is loaded into the output buffer once it has room for it.
// Reset (aresetn low, synchronous) clears registers, row state and both channels.
// Either side may stall at any time; the input register and output buffer
// keep every word.
module differential_manchester_decoder #(
    parameter int ROW_BITS = dmd_pkg::DMD_ROW_BITS
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [0] half_bit, [7:1] zero
    input  wire logic        s_tlast,   // row_end
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [0] value, [11:1] end_position, [15:12] zero
    output logic             m_tuser,   // kind
    output logic             m_tlast,   // final_res
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import dmd_pkg::*;

    // Counter width holds ROW_BITS + 1; compares against the 11-bit pair limit
    // and 10-bit offset happen at the wider of the two.
    localparam int CNT_W  = $clog2(ROW_BITS + 2);
    localparam int WIDE_W = (CNT_W > 11) ? CNT_W : 11;
    localparam int SUM_W  = WIDE_W + 1;
    localparam int ITERS  = 4;

    localparam logic REG_START_OFFSET = 1'b0;
    localparam logic REG_MAX_PAIRS    = 1'b1;

    // configuration registers
    logic [9:0] start_offset_reg;
    logic [9:0] max_pairs_reg;
    logic       cfg_write;

    // input register
    logic       in_valid_reg;
    logic       in_bit_reg;
    logic       in_end_reg;

    // row state
    dmd_phase_t       phase_reg;
    logic [2:0]       held_bits_reg;
    logic [1:0]       held_count_reg;
    logic             clk_ref_reg;
    logic [CNT_W-1:0] position_reg;
    logic [CNT_W-1:0] halves_taken_reg;

    dmd_phase_t       phase_next;
    logic [2:0]       held_bits_next;
    logic [1:0]       held_count_next;
    logic             clk_ref_next;
    logic [CNT_W-1:0] position_next;
    logic [CNT_W-1:0] halves_taken_next;

    // decode path
    logic             fire;
    logic             can_load;
    dmd_batch_t       batch;
    dmd_word_t        out_word;
    dmd_core_t        core;
    dmd_iter_t        step;
    logic [CNT_W-1:0] pos;
    logic [CNT_W-1:0] taken;
    logic [CNT_W-1:0] cap;
    logic [WIDE_W-1:0] lim;
    logic             lim_on;
    logic             ended;
    logic             active;
    logic             reported;
    logic             clear_row;
    logic [1:0]       n_words;
    logic [SUM_W-1:0] end_sum;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_offset_reg <= 10'd0;
            max_pairs_reg    <= 10'd0;
        end else if (cfg_write) begin
            case (paddr[2])
                REG_START_OFFSET: start_offset_reg <= pwdata[9:0];
                REG_MAX_PAIRS:    max_pairs_reg    <= pwdata[9:0];
                default:          ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_START_OFFSET: prdata = {22'd0, start_offset_reg};
            REG_MAX_PAIRS:    prdata = {22'd0, max_pairs_reg};
            default:          prdata = 32'd0;
        endcase
    end

    // ---------------- input register ----------------
    // Take a new word when none is held or the held one is decoded this cycle.
    assign fire     = in_valid_reg && can_load;
    assign s_tready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_bit_reg <= s_tdata[0];
            in_end_reg <= s_tlast;
        end
    end

    // ---------------- decode ----------------
    // Half-bits at row positions ROW_BITS and up are dropped.
    always_comb begin
        if (WIDE_W'(ROW_BITS) > WIDE_W'(start_offset_reg)) begin
            cap = CNT_W'(WIDE_W'(ROW_BITS) - WIDE_W'(start_offset_reg));
        end else begin
            cap = '0;
        end
    end

    assign lim    = WIDE_W'({max_pairs_reg, 1'b0});
    assign lim_on = (max_pairs_reg != 10'd0);

    // Add the new half-bit, then run the decode step until it waits for more
    // input or the run finishes. Each step moves at most one result word, and
    // the sync-to-decode switch happens once, so four steps cover any word.
    always_comb begin
        core     = '{phase: phase_reg, held_bits: held_bits_reg,
                     held_count: held_count_reg, clk_ref: clk_ref_reg};
        pos      = position_reg;
        taken    = halves_taken_reg;
        batch    = '0;
        n_words  = 2'd0;
        reported = 1'b0;
        active   = 1'b0;
        ended    = 1'b0;
        step     = '0;
        end_sum  = '0;

        if (phase_reg != PH_DONE) begin
            active = 1'b1;
            if (taken < cap) begin
                core.held_bits[core.held_count] = in_bit_reg;
                core.held_count = core.held_count + 2'd1;
                taken = taken + CNT_W'(1);
            end
            ended = in_end_reg || (taken >= cap);

            for (int i = 0; i < ITERS; i++) begin
                if (active) begin
                    step = dmd_iter(core, ended,
                                    lim_on && (WIDE_W'(pos) >= lim));
                    core = step.core;
                    pos  = pos + CNT_W'(step.adv);
                    if (step.emit_bit) begin
                        batch.word[n_words] = '{kind: KIND_BIT, value: step.bit_value,
                                                end_position: 11'd0, final_res: 1'b0};
                        n_words = n_words + 2'd1;
                    end
                    if (step.report) begin
                        end_sum = SUM_W'(start_offset_reg) + SUM_W'(pos);
                        batch.word[n_words] = '{kind: KIND_REPORT, value: 1'b0,
                                                end_position: end_sum[10:0],
                                                final_res: 1'b1};
                        n_words  = n_words + 2'd1;
                        reported = 1'b1;
                    end
                    if (step.halt) begin
                        active = 1'b0;
                    end
                end
            end
        end
        batch.cnt = n_words;

        // Row ends: either the report carries row_end, or we drop words after
        // the report until row_end arrives.
        clear_row = in_end_reg && (reported || phase_reg == PH_DONE);

        phase_next        = core.phase;
        held_bits_next    = core.held_bits;
        held_count_next   = core.held_count;
        clk_ref_next      = core.clk_ref;
        position_next     = pos;
        halves_taken_next = taken;
        if (clear_row) begin
            phase_next        = PH_SYNC;
            held_bits_next    = 3'd0;
            held_count_next   = 2'd0;
            clk_ref_next      = 1'b0;
            position_next     = '0;
            halves_taken_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_SYNC;
            held_bits_reg    <= 3'd0;
            held_count_reg   <= 2'd0;
            clk_ref_reg      <= 1'b0;
            position_reg     <= '0;
            halves_taken_reg <= '0;
        end else if (fire) begin
            phase_reg        <= phase_next;
            held_bits_reg    <= held_bits_next;
            held_count_reg   <= held_count_next;
            clk_ref_reg      <= clk_ref_next;
            position_reg     <= position_next;
            halves_taken_reg <= halves_taken_next;
        end
    end

    // ---------------- output buffer ----------------
    dmd_result_buf u_result_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (fire),
        .batch     (batch),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_word  (out_word),
        .can_load  (can_load)
    );

    assign m_tdata = {4'd0, out_word.end_position, out_word.value};
    assign m_tuser = out_word.kind;
    assign m_tlast = out_word.final_res;

endmodule

`default_nettype wire

// File: rtl/core/dmd_checker.sv
`default_nettype none

`include "assert_macros.svh"

module dmd_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic        m_tuser,
    input wire logic        m_tlast,
    input wire logic        psel,
    input wire logic        penable,
    input wire logic        pwrite,
    input wire logic [2:0]  paddr,
    input wire logic [31:0] pwdata,
    input wire logic [31:0] prdata,
    input wire logic        pready
);

    logic        out_stall;
    logic [17:0] out_word;
    logic        cfg_write;

    assign out_stall = m_tvalid && !m_tready;
    assign out_word  = {m_tlast, m_tuser, m_tdata};
    assign cfg_write = psel && penable && pwrite && pready;

    property p_out_hold;
        out_stall |=> m_tvalid && $stable(out_word);
    endproperty

    property p_stall_cause;
        !s_tready |-> m_tvalid;
    endproperty

    property p_report_last;
        m_tvalid |-> (m_tuser == m_tlast);
    endproperty

    property p_cfg_readback;
        cfg_write |=> (paddr[2] != $past(paddr[2]))
                      || (prdata == {22'd0, $past(pwdata[9:0])});
    endproperty

    property p_reset_idle;
        !aresetn |=> !m_tvalid;
    endproperty

    // A stalled result word holds.
    `DMD_ASSERT(a_out_hold, aclk, aresetn, p_out_hold, "result word changed while stalled")

    // Input backpressure only comes from a pending result.
    `DMD_ASSERT(a_stall_cause, aclk, aresetn, p_stall_cause, "input stalled, no result")

    // A report word is always the last of its run.
    `DMD_ASSERT(a_report_last, aclk, aresetn, p_report_last, "report and last disagree")

    // A register write reads back on the next cycle.
    `DMD_ASSERT(a_cfg_readback, aclk, aresetn, p_cfg_readback, "register readback mismatch")

    // Reset empties the result channel.
    `DMD_ASSERT_ALWAYS(a_reset_idle, aclk, p_reset_idle, "result valid after reset")

endmodule

bind differential_manchester_decoder dmd_checker u_dmd_checker (.*);

`default_nettype wire

// File: tb/differential_manchester_decoder_tb.sv
`timescale 1ns / 1ps

module differential_manchester_decoder_tb;
    import dmd_pkg::*;

    // Register map: byte address of each configuration register.
    localparam logic [2:0] ADDR_START_OFFSET = 3'h0;
    localparam logic [2:0] ADDR_MAX_PAIRS    = 3'h4;

    // Random part: input words to push after the directed rows.
    localparam int RANDOM_WORDS = 90;
    // Cycles to let pass once nothing is due, covering the input register and output buffer.
    localparam int SETTLE_CYCLES = 8;
    // Hard stop for the whole run.
    localparam int LIMIT_CYCLES = 200000;

    // Shadow of the decoder: tracks row state and registers, and holds the
    // result words that the block owes us, oldest first.
    class decoded_word_board;
        logic [9:0]  start_off;
        logic [9:0]  pair_cap;
        dmd_phase_t  phase;
        logic [3:0]  held;
        int          held_n;
        logic        clk_ref;
        int          pos;
        int          taken;
        dmd_word_t   words_due[$];
        int          mismatches;

        function new();
            start_off  = '0;
            pair_cap   = '0;
            mismatches = 0;
            clear_row();
        endfunction

        function void clear_row();
            phase   = PH_SYNC;
            held    = '0;
            held_n  = 0;
            clk_ref = 1'b0;
            pos     = 0;
            taken   = 0;
        endfunction

        function void set_reg(logic [2:0] addr, logic [9:0] val);
            if (addr == ADDR_START_OFFSET) begin
                start_off = val;
            end else if (addr == ADDR_MAX_PAIRS) begin
                pair_cap = val;
            end
        endfunction

        // Half-bits past what is held read as zero.
        function logic held_at(int k);
            return (k < held_n) ? held[k] : 1'b0;
        endfunction

        function void consume(int k);
            pos += k;
            if (k >= held_n) begin
                held   = '0;
                held_n = 0;
            end else begin
                held   = held >> k;
                held_n = held_n - k;
            end
        endfunction

        function void owe(logic kind, logic value, logic [10:0] endp, logic fin);
            dmd_word_t w;
            w.kind         = kind;
            w.value        = value;
            w.end_position = endp;
            w.final_res    = fin;
            words_due.push_back(w);
        endfunction

        // Note one accepted input word; returns 1 unless the block ignores it.
        function bit take_half_bit(logic hb, logic row_end);
            int   cap;
            int   lim;
            bit   ended;
            bit   stop;
            logic b1;
            logic b2;
            logic b3;
            cap = (DMD_ROW_BITS > int'(start_off)) ? DMD_ROW_BITS - int'(start_off) : 0;
            lim = int'(pair_cap) * 2;

            // After the report, drop everything up to the end of the row.
            if (phase == PH_DONE) begin
                if (row_end) clear_row();
                return 1'b0;
            end

            // Half-bits beyond the row buffer are dropped.
            if (taken < cap) begin
                held[held_n] = hb;
                held_n++;
                taken++;
            end
            ended = row_end || (taken >= cap);

            forever begin
                stop = 1'b0;
                if (lim != 0 && pos >= lim) begin
                    stop = 1'b1;
                end else if (held_n == 0) begin
                    if (ended) stop = 1'b1;
                    else break;
                end

                if (!stop && phase == PH_SYNC) begin
                    // Sync looks one half-bit ahead of the pair.
                    if (held_n < 3 && !ended) break;
                    b1 = held_at(0);
                    b2 = held_at(1);
                    b3 = held_at(2);
                    if (b1 != b2) begin
                        if (b2 != b3) begin
                            owe(KIND_BIT, 1'b0, '0, 1'b0);
                            consume(2);
                        end else begin
                            clk_ref = b1;
                            consume(1);
                            phase = PH_DECODE;
                        end
                    end else begin
                        clk_ref = ~b1;
                        phase   = PH_DECODE;
                    end
                    continue;
                end

                if (!stop) begin
                    b1 = held_at(0);
                    if (b1 == clk_ref) begin
                        // Missing clock transition: abort the row.
                        consume(1);
                        stop = 1'b1;
                    end else begin
                        if (held_n < 2 && !ended) break;
                        b2 = held_at(1);
                        owe(KIND_BIT, b1 == b2, '0, 1'b0);
                        clk_ref = b2;
                        consume(2);
                        continue;
                    end
                end

                owe(KIND_REPORT, 1'b0, 11'(int'(start_off) + pos), 1'b1);
                if (row_end) begin
                    clear_row();
                end else begin
                    phase  = PH_DONE;
                    held   = '0;
                    held_n = 0;
                end
                break;
            end
            return 1'b1;
        endfunction

        function void match_word(logic kind, logic value, logic [10:0] endp, logic fin);
            dmd_word_t w;
            if (words_due.size() == 0) begin
                $error("result word with none due: kind %0d value %0d end_position %0d",
                       kind, value, endp);
                mismatches++;
                return;
            end
            w = words_due.pop_front();
            if (kind !== w.kind) begin
                $error("kind: expected %0d, got %0d", w.kind, kind);
                mismatches++;
            end
            if (value !== w.value) begin
                $error("value: expected %0d, got %0d", w.value, value);
                mismatches++;
            end
            if (endp !== w.end_position) begin
                $error("end_position: expected %0d, got %0d", w.end_position, endp);
                mismatches++;
            end
            if (fin !== w.final_res) begin
                $error("final_res: expected %0d, got %0d", w.final_res, fin);
                mismatches++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;   // [0] half_bit, [7:1] zero
    logic        s_tlast  = 1'b0; // row_end
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;         // [0] value, [11:1] end_position, [15:12] zero
    logic        m_tuser;         // kind
    logic        m_tlast;         // final_res
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    differential_manchester_decoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    decoded_word_board board = new();

    // Row being sent, one half-bit per entry.
    logic row_bits[$];
    // Count of input words accepted by the decoder.
    int   used_words = 0;
    // Sender pacing: words left in the current burst, and whether the
    // current phase runs without gaps at all.
    int   burst_left = 0;
    bit   steady     = 1'b0;
    // Tracks whether s_tvalid is scheduled high, so it is never driven twice
    // within one time step.
    bit   valid_high = 1'b0;
    int   cycles     = 0;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Timeout watchdog.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("differential_manchester_decoder_tb: done, errors");
            $finish;
        end
    end

    // Result side: check every accepted word, then pick the next tready.
    // The mode is redrawn at random at each rx_tick boundary: always ready, coin
    // flips, or a fixed duty pattern with short stalls.
    int rx_mode = 0;
    int rx_tick = 0;
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            board.match_word(m_tuser, m_tdata[0], m_tdata[11:1], m_tlast);
        end
        rx_tick <= rx_tick + 1;
        if (rx_tick % 64 == 63) rx_mode <= $urandom_range(0, 2);
        case (rx_mode)
            0: begin
                m_tready <= 1'b1;
            end
            1: begin
                m_tready <= 1'($urandom_range(0, 1));
            end
            default: begin
                m_tready <= (rx_tick % 7) >= 3;
            end
        endcase
    end

    // APB write with setup and access phases; the shadow register updates on the access edge.
    task automatic write_reg(logic [2:0] addr, logic [9:0] val);
        psel   <= 1'b1;
        pwrite <= 1'b1;
        paddr  <= addr;
        pwdata <= {22'd0, val};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        board.set_reg(addr, val);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic configure(logic [9:0] offset, logic [9:0] pairs);
        write_reg(ADDR_START_OFFSET, offset);
        write_reg(ADDR_MAX_PAIRS, pairs);
    endtask

    // Offer one word, wait for the handshake, then maybe open a gap.
    task automatic send_word(logic hb, logic row_end);
        int gap;
        gap = 0;
        s_tvalid   <= 1'b1;
        s_tdata    <= {7'd0, hb};
        s_tlast    <= row_end;
        valid_high = 1'b1;
        do @(posedge aclk); while (!s_tready);
        void'(board.take_half_bit(hb, row_end));
        used_words++;
        if (!steady) begin
            if (burst_left <= 0) begin
                gap        = $urandom_range(1, 6);
                burst_left = $urandom_range(1, 12);
            end
            burst_left--;
        end
        if (gap > 0) begin
            s_tvalid   <= 1'b0;
            valid_high = 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_row();
        foreach (row_bits[i]) send_word(row_bits[i], i == row_bits.size() - 1);
    endtask

    task automatic send_list(logic hb[$]);
        row_bits = hb;
        send_row();
    endtask

    // Drop valid, drain every owed word, then let the pipeline settle so
    // that registers are only written while the block is idle.
    task automatic wait_idle();
        if (valid_high) begin
            s_tvalid   <= 1'b0;
            valid_high = 1'b0;
        end
        do @(posedge aclk); while (board.words_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Build a row: mostly clean differential coding with random data,
    // sometimes with a flipped half-bit, sometimes pure noise.
    task automatic build_row();
        int   nbits;
        int   pick;
        logic r;
        logic h1;
        logic h2;
        row_bits.delete();
        nbits = $urandom_range(1, 12);
        pick  = $urandom_range(0, 19);
        if (pick >= 17) begin
            repeat (2 * nbits) row_bits.push_back(1'($urandom_range(0, 1)));
        end else begin
            // Occasional junk in front of the sync point.
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 3)) row_bits.push_back(1'($urandom_range(0, 1)));
            end
            r = 1'($urandom_range(0, 1));
            repeat (nbits) begin
                h1 = ~r;
                h2 = $urandom_range(0, 1) ? h1 : ~h1;
                row_bits.push_back(h1);
                row_bits.push_back(h2);
                r = h2;
            end
            if (pick >= 14) begin
                pick = $urandom_range(0, row_bits.size() - 1);
                row_bits[pick] = ~row_bits[pick];
            end
            // Odd-length rows exercise the lookahead past the row end.
            if ($urandom_range(0, 3) == 0) row_bits.push_back(1'($urandom_range(0, 1)));
        end
    endtask

    initial begin
        int          target;
        logic [9:0]  offset;
        logic [9:0]  pairs;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed rows.
        steady = 1'b0;
        configure(10'd0, 10'd0);
        // Single half-bit: lookahead past the row end.
        send_list('{1'b1});
        // Unequal pair then a change decodes as zero during sync.
        send_list('{1'b0, 1'b1, 1'b0, 1'b0});
        // Equal first pair enters decoding at once; end one past the row.
        send_list('{1'b1, 1'b1, 1'b0, 1'b0, 1'b1});
        // Abort on a missing transition, then words ignored until row end.
        send_list('{1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1});
        wait_idle();

        // Top offset: one half-bit fits, the rest of the row is dropped.
        configure(10'd1023, 10'd1023);
        send_list('{1'b0, 1'b1, 1'b1, 1'b0});
        wait_idle();

        // Pair limit of one, with row half-bits read past it as lookahead.
        configure(10'd5, 10'd1);
        send_list('{1'b1, 1'b1, 1'b0, 1'b0});
        wait_idle();

        // Random phases, each with its own registers and pacing.
        target = used_words + RANDOM_WORDS;
        while (used_words < target) begin
            case ($urandom_range(0, 6))
                0:       offset = 10'($urandom_range(1000, 1023));
                1:       offset = 10'($urandom);
                default: offset = 10'($urandom_range(0, 50));
            endcase
            case ($urandom_range(0, 9))
                0:       pairs = 10'd512;
                1:       pairs = 10'($urandom);
                2, 3, 4: pairs = 10'($urandom_range(1, 8));
                default: pairs = 10'd0;
            endcase
            steady = ($urandom_range(0, 3) == 0);
            configure(offset, pairs);
            repeat ($urandom_range(1, 3)) begin
                build_row();
                send_row();
            end
            wait_idle();
        end

        if (board.mismatches == 0) begin
            $display("differential_manchester_decoder_tb: done, clean");
        end else begin
            $display("differential_manchester_decoder_tb: done, errors");
        end
        $finish;
    end

endmodule

// File: differential_manchester_decoder.f
+incdir+rtl/core
rtl/core/dmd_pkg.sv
rtl/core/dmd_result_buf.sv
rtl/core/differential_manchester_decoder.sv
rtl/core/dmd_checker.sv
tb/differential_manchester_decoder_tb.sv
